// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the culling core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is held.
`define FAC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Clocked check that also runs during reset.
`define FAC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ===== rtl/fac_pkg.sv =====
// Types, constants and helper functions of the frustum culling core.
`default_nettype none
package fac_pkg;

    localparam int WORD_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int SUM_W   = WORD_W + 4;
    localparam int PROD_W  = 2 * WORD_W;
    localparam int MAG_W   = WORD_W + FRAC_W;
    localparam int DOT_W   = PROD_W + 4;
    localparam int SQ_IN_W = PROD_W;
    localparam int SQ_W    = WORD_W;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [1:0] {
        FUNC_LOAD_VIEW = 2'd0,
        FUNC_LOAD_PROJ = 2'd1,
        FUNC_DERIVE    = 2'd2,
        FUNC_TEST_BOX  = 2'd3
    } t_func;

    typedef enum logic {
        DS_SQRT = 1'b0,
        DS_DIV  = 1'b1
    } t_ds_mode;

    typedef struct packed {
        logic     start;
        t_ds_mode mode;
    } t_ds_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_ds_stat;

    // Clamp a widened sum into the word range.
    function automatic t_word sat_word(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = {{(SUM_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
        lo = ~hi;
        if (v > hi) begin
            return hi[WORD_W-1:0];
        end else if (v < lo) begin
            return lo[WORD_W-1:0];
        end
        return v[WORD_W-1:0];
    endfunction

    // Signed word from a magnitude and a sign, clamped to the word range.
    function automatic t_word from_mag(input logic [MAG_W-1:0] m, input logic neg);
        logic [MAG_W-1:0] cap;
        logic [MAG_W-1:0] mm;
        cap = neg ? (MAG_W'(1) << (WORD_W-1)) : ((MAG_W'(1) << (WORD_W-1)) - MAG_W'(1));
        mm  = (m > cap) ? cap : m;
        return neg ? t_word'(-mm[WORD_W-1:0]) : t_word'(mm[WORD_W-1:0]);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/fac_stream_if.sv =====
// Command and result channel interfaces of the frustum culling core.
`default_nettype none
interface fac_cmd_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                func;
    logic [3:0]                element_index;
    logic signed [31:0]        element_value;
    logic signed [31:0]        min_x;
    logic signed [31:0]        min_y;
    logic signed [31:0]        min_z;
    logic signed [31:0]        max_x;
    logic signed [31:0]        max_y;
    logic signed [31:0]        max_z;

    modport source (output valid, func, element_index, element_value,
                    min_x, min_y, min_z, max_x, max_y, max_z, input ready);
    modport sink   (input valid, func, element_index, element_value,
                    min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

interface fac_res_if;
    logic       valid;
    logic       ready;
    logic       visible;
    logic [1:0] done_func;
    logic       degenerate;

    modport source (output valid, visible, done_func, degenerate, input ready);
    modport sink   (input valid, visible, done_func, degenerate, output ready);
endinterface
`default_nettype wire

// ===== rtl/fac_mul.sv =====
// Registered signed word multiplier shared by the matrix, squaring and box products of the core.
`default_nettype none
module fac_mul
    import fac_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic signed [WORD_W-1:0] i_a,
    input  wire logic signed [WORD_W-1:0] i_b,
    output logic signed [PROD_W-1:0]      o_p
);

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= PROD_W'(i_a) * PROD_W'(i_b);
        end
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

// ===== rtl/fac_divsqrt.sv =====
// Iterative integer square root and restoring divider, one digit per cycle.
`default_nettype none
`include "assert_macros.svh"
module fac_divsqrt
    import fac_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_ds_req            i_req,
    input  wire logic [SQ_IN_W-1:0] i_sq_arg,
    input  wire logic [MAG_W-1:0]   i_num,
    input  wire logic [SQ_W-1:0]    i_den,
    output t_ds_stat                o_stat,
    output logic [SQ_W-1:0]         o_root,
    output logic [MAG_W-1:0]        o_quot
);

    localparam int CNT_W = $clog2(MAG_W);
    localparam int REM_W = SQ_W + 2;

    logic               r_busy;
    logic               r_done;
    t_ds_mode           r_mode;
    logic [CNT_W-1:0]   r_cnt;
    logic [SQ_IN_W-1:0] r_rad;
    logic [REM_W-1:0]   r_rem;
    logic [SQ_W-1:0]    r_root;
    logic [MAG_W-1:0]   r_num;
    logic [SQ_W-1:0]    r_den;

    logic [REM_W+1:0]   sq_rem2;
    logic [REM_W+1:0]   sq_trial;
    logic [SQ_W:0]      dv_rem2;
    logic [SQ_W:0]      dv_den;

    always_comb begin
        sq_rem2  = {r_rem, r_rad[SQ_IN_W-1 -: 2]};
        sq_trial = {2'b00, r_root, 2'b01};
        dv_rem2  = {r_rem[SQ_W-1:0], r_num[MAG_W-1]};
        dv_den   = {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_mode <= DS_SQRT;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_mode <= i_req.mode;
                r_rem  <= '0;
                r_root <= '0;
                r_rad  <= i_sq_arg;
                r_num  <= i_num;
                r_den  <= i_den;
                r_cnt  <= (i_req.mode == DS_DIV) ? CNT_W'(MAG_W - 1) : CNT_W'(SQ_W - 1);
            end else if (r_busy) begin
                if (r_mode == DS_SQRT) begin
                    r_rad <= r_rad << 2;
                    if (sq_rem2 >= sq_trial) begin
                        r_rem  <= REM_W'(sq_rem2 - sq_trial);
                        r_root <= {r_root[SQ_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= REM_W'(sq_rem2);
                        r_root <= {r_root[SQ_W-2:0], 1'b0};
                    end
                end else begin
                    if (dv_rem2 >= dv_den) begin
                        r_rem <= REM_W'(dv_rem2 - dv_den);
                        r_num <= {r_num[MAG_W-2:0], 1'b1};
                    end else begin
                        r_rem <= REM_W'(dv_rem2);
                        r_num <= {r_num[MAG_W-2:0], 1'b0};
                    end
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_root      = r_root;
    assign o_quot      = r_num;

    `FAC_ASSERT(a_no_start_busy, i_clk, i_rst_n, i_req.start |-> !r_busy)
    `FAC_ASSERT(a_done_after_busy, i_clk, i_rst_n, r_done |-> ($past(r_busy) && !r_busy))

endmodule
`default_nettype wire

// ===== rtl/frustum_aabb_culling_core.sv =====
// Top level of the frustum culling core: command sequencer, matrix and plane storage.
//
// Usage: commands arrive as beats on the i_cmd channel and every command
// gives exactly one beat on the o_res channel, in order. A beat moves when
// valid and ready are both high at a rising clock edge. Loading a view or
// projection element writes it when the command is accepted; its result
// beat follows on the next cycle. A box test runs each plane as three
// products on the shared multiplier, each a multiply step and an
// accumulate step, plus one compare step, ending early at the first plane
// that rejects the box. A derive runs 64 products for the clip matrix,
// then for each of the six planes three squaring products, a 32-bit
// square root and four 48-bit divisions on the iterative unit; a plane
// with a zero normal skips that work. The block takes one command at a
// time: i_cmd.ready is high only while the sequencer is idle and the
// result register is empty or being drained in the same cycle. When the
// receiver stalls, the result beat holds in the output register and no
// further command is taken. Reset (synchronous, active low) clears both
// matrices and all planes, so every box is visible until a derive has run.
`default_nettype none
`include "assert_macros.svh"
module frustum_aabb_culling_core
    import fac_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fac_cmd_if.sink   i_cmd,
    fac_res_if.source o_res
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MM_MUL,
        S_MM_ACC,
        S_PL_RAW,
        S_PL_NORM,
        S_PL_SQ_MUL,
        S_PL_SQ_ACC,
        S_PL_SQRT_GO,
        S_PL_SQRT,
        S_PL_DIV_GO,
        S_PL_DIV,
        S_BOX_MUL,
        S_BOX_ACC,
        S_BOX_CMP
    } t_state;

    t_state r_state;

    // Matrix and plane storage. Elements sit at column times four plus row;
    // plane p keeps a, b, c, d at 4p to 4p+3.
    t_word r_view  [16];
    t_word r_proj  [16];
    t_word r_clip  [16];
    t_word r_plane [24];

    // Sequencer counters.
    logic [3:0] r_e;
    logic [1:0] r_k;
    logic [2:0] r_p;
    logic [1:0] r_j;

    logic signed [SUM_W-1:0] r_acc;
    t_word                   r_raw [4];
    logic [WORD_W-1:0]       r_m   [4];
    logic [SQ_IN_W-1:0]      r_sum;
    logic [SQ_W-1:0]         r_len;
    logic                    r_degen;

    t_word                   r_lo [3];
    t_word                   r_hi [3];
    logic signed [DOT_W-1:0] r_dot;

    logic       r_out_valid;
    logic       r_out_visible;
    logic [1:0] r_out_func;
    logic       r_out_degen;

    // Shared multiplier.
    logic                     mul_en;
    logic signed [WORD_W-1:0] mul_a;
    logic signed [WORD_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;

    // Iterative root and divide unit.
    t_ds_req          ds_req;
    t_ds_stat         ds_stat;
    logic [SQ_W-1:0]  ds_root;
    logic [MAG_W-1:0] ds_quot;
    logic [MAG_W-1:0] ds_num;

    logic in_ready;
    logic in_accept;

    // Working values of the current step.
    logic [PROD_W-1:0]       prod_mag;
    t_word                   prod_fix;
    logic signed [SUM_W-1:0] acc_next;
    logic [1:0]              row_sel;
    t_word                   raw_c   [4];
    logic [WORD_W-1:0]       mag_c   [4];
    logic [WORD_W-1:0]       top_mag;
    logic [1:0]              shift_k;
    t_word                   box_n;
    logic signed [DOT_W-1:0] box_test;

    assign in_ready  = (r_state == S_IDLE) && (!r_out_valid || o_res.ready);
    assign in_accept = i_cmd.valid && in_ready;

    always_comb begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        box_n  = r_plane[{r_p, r_j}];
        case (r_state)
            S_MM_MUL: begin
                mul_en = 1'b1;
                mul_a  = r_proj[{r_k, r_e[1:0]}];
                mul_b  = r_view[{r_e[3:2], r_k}];
            end
            S_PL_SQ_MUL: begin
                mul_en = 1'b1;
                mul_a  = r_m[r_j];
                mul_b  = r_m[r_j];
            end
            S_BOX_MUL: begin
                mul_en = 1'b1;
                mul_a  = box_n;
                mul_b  = box_n[WORD_W-1] ? r_lo[r_j] : r_hi[r_j];
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    fac_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    always_comb begin
        ds_req.start = (r_state == S_PL_SQRT_GO) || (r_state == S_PL_DIV_GO);
        ds_req.mode  = (r_state == S_PL_DIV_GO) ? DS_DIV : DS_SQRT;
        ds_num       = MAG_W'(r_m[r_j]) << FRAC_W;
    end

    fac_divsqrt u_divsqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (ds_req),
        .i_sq_arg (r_sum),
        .i_num    (ds_num),
        .i_den    (r_len),
        .o_stat   (ds_stat),
        .o_root   (ds_root),
        .o_quot   (ds_quot)
    );

    // Fixed-point product truncated toward zero, and the plane arithmetic.
    always_comb begin
        prod_mag = mul_p[PROD_W-1] ? PROD_W'(-mul_p) : PROD_W'(mul_p);
        prod_fix = from_mag(prod_mag[PROD_W-1:FRAC_W], mul_p[PROD_W-1]);
        acc_next = r_acc + SUM_W'(prod_fix);
        row_sel  = r_p[2:1];
        for (int c = 0; c < 4; c++) begin
            if (r_p[0]) begin
                raw_c[c] = sat_word(SUM_W'(r_clip[{c[1:0], 2'd3}])
                                    - SUM_W'(r_clip[{c[1:0], row_sel}]));
            end else begin
                raw_c[c] = sat_word(SUM_W'(r_clip[{c[1:0], 2'd3}])
                                    + SUM_W'(r_clip[{c[1:0], row_sel}]));
            end
            mag_c[c] = r_raw[c][WORD_W-1] ? WORD_W'(-r_raw[c]) : WORD_W'(r_raw[c]);
        end
        top_mag = mag_c[0];
        if (mag_c[1] > top_mag) begin
            top_mag = mag_c[1];
        end
        if (mag_c[2] > top_mag) begin
            top_mag = mag_c[2];
        end
        // Smallest right shift that brings the largest normal component below 2^30.
        if (top_mag[WORD_W-1]) begin
            shift_k = 2'd2;
        end else if (top_mag[WORD_W-2]) begin
            shift_k = 2'd1;
        end else begin
            shift_k = 2'd0;
        end
        box_test = r_dot + (DOT_W'(r_plane[{r_p, 2'd3}]) <<< FRAC_W);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_e         <= '0;
            r_k         <= '0;
            r_p         <= '0;
            r_j         <= '0;
            r_degen     <= 1'b0;
            for (int i = 0; i < 16; i++) begin
                r_view[i] <= '0;
                r_proj[i] <= '0;
            end
            for (int i = 0; i < 24; i++) begin
                r_plane[i] <= '0;
            end
        end else begin
            if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_lo[0] <= i_cmd.min_x;
                        r_lo[1] <= i_cmd.min_y;
                        r_lo[2] <= i_cmd.min_z;
                        r_hi[0] <= i_cmd.max_x;
                        r_hi[1] <= i_cmd.max_y;
                        r_hi[2] <= i_cmd.max_z;
                        r_e     <= '0;
                        r_k     <= '0;
                        r_p     <= '0;
                        r_j     <= '0;
                        r_acc   <= '0;
                        r_dot   <= '0;
                        r_degen <= 1'b0;
                        case (t_func'(i_cmd.func))
                            FUNC_LOAD_VIEW: begin
                                r_view[i_cmd.element_index] <= i_cmd.element_value;
                                r_out_valid   <= 1'b1;
                                r_out_visible <= 1'b0;
                                r_out_func    <= FUNC_LOAD_VIEW;
                                r_out_degen   <= 1'b0;
                            end
                            FUNC_LOAD_PROJ: begin
                                r_proj[i_cmd.element_index] <= i_cmd.element_value;
                                r_out_valid   <= 1'b1;
                                r_out_visible <= 1'b0;
                                r_out_func    <= FUNC_LOAD_PROJ;
                                r_out_degen   <= 1'b0;
                            end
                            FUNC_DERIVE: begin
                                r_state <= S_MM_MUL;
                            end
                            default: begin
                                r_state <= S_BOX_MUL;
                            end
                        endcase
                    end
                end
                S_MM_MUL: begin
                    r_state <= S_MM_ACC;
                end
                S_MM_ACC: begin
                    if (r_k == 2'd3) begin
                        r_clip[r_e] <= sat_word(acc_next);
                        r_acc       <= '0;
                        r_k         <= '0;
                        if (r_e == 4'd15) begin
                            r_state <= S_PL_RAW;
                        end else begin
                            r_e     <= r_e + 4'd1;
                            r_state <= S_MM_MUL;
                        end
                    end else begin
                        r_acc   <= acc_next;
                        r_k     <= r_k + 2'd1;
                        r_state <= S_MM_MUL;
                    end
                end
                S_PL_RAW: begin
                    for (int c = 0; c < 4; c++) begin
                        r_raw[c] <= raw_c[c];
                    end
                    r_state <= S_PL_NORM;
                end
                S_PL_NORM: begin
                    for (int c = 0; c < 4; c++) begin
                        r_m[c] <= mag_c[c] >> shift_k;
                    end
                    r_sum <= '0;
                    r_j   <= '0;
                    if (top_mag == '0) begin
                        // A zero normal leaves a plane that never culls.
                        for (int c = 0; c < 4; c++) begin
                            r_plane[{r_p, c[1:0]}] <= '0;
                        end
                        r_degen <= 1'b1;
                        if (r_p == 3'd5) begin
                            r_state       <= S_IDLE;
                            r_out_valid   <= 1'b1;
                            r_out_visible <= 1'b0;
                            r_out_func    <= FUNC_DERIVE;
                            r_out_degen   <= 1'b1;
                        end else begin
                            r_p     <= r_p + 3'd1;
                            r_state <= S_PL_RAW;
                        end
                    end else begin
                        r_state <= S_PL_SQ_MUL;
                    end
                end
                S_PL_SQ_MUL: begin
                    r_state <= S_PL_SQ_ACC;
                end
                S_PL_SQ_ACC: begin
                    r_sum <= r_sum + SQ_IN_W'(mul_p);
                    if (r_j == 2'd2) begin
                        r_j     <= '0;
                        r_state <= S_PL_SQRT_GO;
                    end else begin
                        r_j     <= r_j + 2'd1;
                        r_state <= S_PL_SQ_MUL;
                    end
                end
                S_PL_SQRT_GO: begin
                    r_state <= S_PL_SQRT;
                end
                S_PL_SQRT: begin
                    if (ds_stat.done) begin
                        r_len   <= ds_root;
                        r_state <= S_PL_DIV_GO;
                    end
                end
                S_PL_DIV_GO: begin
                    r_state <= S_PL_DIV;
                end
                S_PL_DIV: begin
                    if (ds_stat.done) begin
                        r_plane[{r_p, r_j}] <= from_mag(ds_quot, r_raw[r_j][WORD_W-1]);
                        if (r_j == 2'd3) begin
                            r_j <= '0;
                            if (r_p == 3'd5) begin
                                r_state       <= S_IDLE;
                                r_out_valid   <= 1'b1;
                                r_out_visible <= 1'b0;
                                r_out_func    <= FUNC_DERIVE;
                                r_out_degen   <= r_degen;
                            end else begin
                                r_p     <= r_p + 3'd1;
                                r_state <= S_PL_RAW;
                            end
                        end else begin
                            r_j     <= r_j + 2'd1;
                            r_state <= S_PL_DIV_GO;
                        end
                    end
                end
                S_BOX_MUL: begin
                    r_state <= S_BOX_ACC;
                end
                S_BOX_ACC: begin
                    r_dot <= r_dot + DOT_W'(mul_p);
                    if (r_j == 2'd2) begin
                        r_j     <= '0;
                        r_state <= S_BOX_CMP;
                    end else begin
                        r_j     <= r_j + 2'd1;
                        r_state <= S_BOX_MUL;
                    end
                end
                S_BOX_CMP: begin
                    r_dot <= '0;
                    if (box_test[DOT_W-1] || (r_p == 3'd5)) begin
                        r_state       <= S_IDLE;
                        r_out_valid   <= 1'b1;
                        r_out_visible <= !box_test[DOT_W-1];
                        r_out_func    <= FUNC_TEST_BOX;
                        r_out_degen   <= 1'b0;
                    end else begin
                        r_p     <= r_p + 3'd1;
                        r_state <= S_BOX_MUL;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_cmd.ready      = in_ready;
    assign o_res.valid      = r_out_valid;
    assign o_res.visible    = r_out_visible;
    assign o_res.done_func  = r_out_func;
    assign o_res.degenerate = r_out_degen;

    `FAC_ASSERT(a_one_at_a_time, i_clk, i_rst_n, in_accept |=> (r_out_valid || (r_state != S_IDLE)))
    `FAC_ASSERT(a_visible_only_box, i_clk, i_rst_n,
        (r_out_valid && (r_out_func != FUNC_TEST_BOX)) |-> !r_out_visible)
    `FAC_ASSERT(a_degen_only_derive, i_clk, i_rst_n,
        (r_out_valid && (r_out_func != FUNC_DERIVE)) |-> !r_out_degen)

endmodule
`default_nettype wire

// ===== sim/fac_culling_checker.sv =====
// Checker for the frustum culling core: predicts every result beat and compares it.
module fac_culling_checker
    import fac_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fac_cmd_if.sink   cmd_mon,
    fac_res_if.sink   res_mon,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       visible;
        logic [1:0] done_func;
        logic       degenerate;
    } t_culling_result;

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;

    longint view_m [16];
    longint proj_m [16];
    longint planes [24];
    t_culling_result expected_results[$];

    function automatic longint clamp_word(input longint v);
        if (v > WORD_MAX) return WORD_MAX;
        if (v < WORD_MIN) return WORD_MIN;
        return v;
    endfunction

    // Fixed-point product truncated toward zero, clamped to the word range.
    function automatic longint fix_mul(input longint a, input longint b);
        logic [127:0] pa;
        logic [127:0] pm;
        longint       q;
        bit           neg;
        neg = (a < 0) != (b < 0);
        pa  = 128'(a < 0 ? -a : a);
        pm  = (pa * 128'(b < 0 ? -b : b)) >> FRAC_W;
        if (pm > 128'(WORD_MAX) + 1) pm = 128'(WORD_MAX) + 1;
        q = longint'(pm);
        return neg ? clamp_word(-q) : clamp_word(q);
    endfunction

    function automatic longint int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    // Normalizes one plane into the plane store; returns 1 for a zero normal.
    function automatic bit store_plane(input int p, input longint raw[4]);
        longint unsigned mag[4];
        longint unsigned top;
        longint unsigned len;
        longint unsigned sq;
        longint unsigned q;
        int k;
        for (int i = 0; i < 4; i++) mag[i] = raw[i] < 0 ? -raw[i] : raw[i];
        top = mag[0];
        if (mag[1] > top) top = mag[1];
        if (mag[2] > top) top = mag[2];
        if (top == 0) begin
            for (int i = 0; i < 4; i++) planes[4*p+i] = 0;
            return 1'b1;
        end
        k = 0;
        while ((top >> k) >= (64'd1 << 30)) k++;
        for (int i = 0; i < 4; i++) mag[i] >>= k;
        sq = 0;
        for (int i = 0; i < 3; i++) sq += mag[i] * mag[i];
        len = int_sqrt(sq);
        for (int i = 0; i < 4; i++) begin
            q = (mag[i] << FRAC_W) / len;
            if (raw[i] < 0) planes[4*p+i] = q > 64'd2147483648 ? WORD_MIN : -longint'(q);
            else planes[4*p+i] = q > 64'd2147483647 ? WORD_MAX : longint'(q);
        end
        return 1'b0;
    endfunction

    function automatic bit derive_planes();
        longint clip[4][4];
        longint raw[4];
        longint acc;
        bit     degen;
        degen = 1'b0;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) begin
                acc = 0;
                for (int k = 0; k < 4; k++) acc += fix_mul(proj_m[k*4+r], view_m[c*4+k]);
                clip[r][c] = clamp_word(acc);
            end
        for (int p = 0; p < 6; p++) begin
            for (int c = 0; c < 4; c++)
                raw[c] = clamp_word(p[0] ? clip[3][c] - clip[p>>1][c]
                                         : clip[3][c] + clip[p>>1][c]);
            if (store_plane(p, raw)) degen = 1'b1;
        end
        return degen;
    endfunction

    // The box is culled by the first plane with its farthest corner behind it.
    function automatic bit box_in_view(input longint lo[3], input longint hi[3]);
        longint n;
        longint dot;
        for (int p = 0; p < 6; p++) begin
            dot = 0;
            for (int i = 0; i < 3; i++) begin
                n = planes[4*p+i];
                dot += n * (n >= 0 ? hi[i] : lo[i]);
            end
            if ((dot >>> FRAC_W) + planes[4*p+3] < 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_culling_result exp_r;
        t_culling_result got;
        longint lo[3];
        longint hi[3];
        if (!i_rst_n) begin
            foreach (view_m[i]) begin
                view_m[i] = 0;
                proj_m[i] = 0;
            end
            foreach (planes[i]) planes[i] = 0;
            expected_results.delete();
            o_fail_count <= 0;
        end else begin
            if (res_mon.valid && res_mon.ready) begin
                got = '{res_mon.visible, res_mon.done_func, res_mon.degenerate};
                if (expected_results.size() == 0) begin
                    $error("unexpected result beat");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got.visible !== exp_r.visible)
                        $error("visible: expected %0d actual %0d", exp_r.visible, got.visible);
                    if (got.done_func !== exp_r.done_func)
                        $error("done_func: expected %0d actual %0d",
                               exp_r.done_func, got.done_func);
                    if (got.degenerate !== exp_r.degenerate)
                        $error("degenerate: expected %0d actual %0d",
                               exp_r.degenerate, got.degenerate);
                    if (got !== exp_r) o_fail_count <= o_fail_count + 1;
                end
            end
            if (cmd_mon.valid && cmd_mon.ready) begin
                exp_r = '{1'b0, cmd_mon.func, 1'b0};
                case (t_func'(cmd_mon.func))
                    FUNC_LOAD_VIEW: view_m[cmd_mon.element_index] = cmd_mon.element_value;
                    FUNC_LOAD_PROJ: proj_m[cmd_mon.element_index] = cmd_mon.element_value;
                    FUNC_DERIVE:    exp_r.degenerate = derive_planes();
                    default: begin
                        lo = '{cmd_mon.min_x, cmd_mon.min_y, cmd_mon.min_z};
                        hi = '{cmd_mon.max_x, cmd_mon.max_y, cmd_mon.max_z};
                        exp_r.visible = box_in_view(lo, hi);
                    end
                endcase
                expected_results.push_back(exp_r);
            end
        end
    end
endmodule

// ===== sim/tb_frustum_aabb_culling_core.sv =====
// Testbench top of the frustum culling core: stimulus, idling and verdict.
module tb_frustum_aabb_culling_core;
    import fac_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 900000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count;
    int   beats_sent;
    bit   calm_phase;

    fac_cmd_if cmd_ch();
    fac_res_if res_ch();

    frustum_aabb_culling_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch.sink),
        .o_res  (res_ch.source)
    );

    fac_culling_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .cmd_mon     (cmd_ch.sink),
        .res_mon     (res_ch.sink),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // A global cycle budget stops a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // The receiver stalls in random bursts, except near the end of the run.
    initial begin
        int gap;
        res_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!calm_phase && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 17);
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    // Random Q16.16 value: mostly moderate, sometimes at the extremes.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom();
            3: return 32'(int'($urandom_range(0, 8 << 16)) - (4 << 16));
            default: return 32'(int'($urandom_range(0, 2 << 16)) - (1 << 16));
        endcase
    endfunction

    // Sends one command beat; the sender idles in random bursts before it.
    task automatic send_beat(input t_func op, input logic [3:0] idx, input logic [31:0] val,
                             input logic [31:0] box[6]);
        if (!calm_phase && $urandom_range(0, 4) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        cmd_ch.valid         <= 1'b1;
        cmd_ch.func          <= op;
        cmd_ch.element_index <= idx;
        cmd_ch.element_value <= val;
        cmd_ch.min_x <= box[0];
        cmd_ch.min_y <= box[1];
        cmd_ch.min_z <= box[2];
        cmd_ch.max_x <= box[3];
        cmd_ch.max_y <= box[4];
        cmd_ch.max_z <= box[5];
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic send_box(input logic [31:0] lo, input logic [31:0] hi);
        logic [31:0] box[6];
        box = '{lo, lo, lo, hi, hi, hi};
        send_beat(FUNC_TEST_BOX, 4'd0, 32'd0, box);
    endtask

    task automatic send_random_box();
        logic [31:0] box[6];
        int c;
        for (int i = 0; i < 3; i++) begin
            c = int'($urandom_range(0, 40 << 16)) - (20 << 16);
            box[i]     = ($urandom_range(0, 15) == 0) ? pick_value() : 32'(c);
            box[i + 3] = ($urandom_range(0, 15) == 0) ? pick_value()
                       : 32'(c + int'($urandom_range(0, 8 << 16)));
        end
        send_beat(FUNC_TEST_BOX, 4'd0, 32'd0, box);
    endtask

    // Loads a perspective-like projection and a random view, or random values for both when noisy, then derives.
    task automatic load_frame(input bit noisy);
        logic [31:0] box[6];
        logic [31:0] val;
        box = '{default: 32'd0};
        for (int i = 0; i < 16; i++) begin
            val = (i % 5 == 0) ? 32'h0001_0000 : 32'(int'($urandom_range(0, 1 << 16)) - (1 << 15));
            if (noisy) val = pick_value();
            send_beat(FUNC_LOAD_VIEW, 4'(i), val, box);
        end
        for (int i = 0; i < 16; i++) begin
            case (i)
                0, 5:    val = 32'(int'($urandom_range(1 << 15, 3 << 16)));
                10:      val = 32'hFFFE_0000;
                11:      val = 32'hFFFF_0000;
                14:      val = 32'hFFFF_8000;
                default: val = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 4096)) : 0;
            endcase
            if (noisy) val = pick_value();
            send_beat(FUNC_LOAD_PROJ, 4'(i), val, box);
        end
        send_beat(FUNC_DERIVE, 4'd0, 32'd0, box);
    endtask

    initial begin
        logic [31:0] box[6];
        cycle_count = 0;
        beats_sent  = 0;
        calm_phase  = 1'b0;
        box = '{default: 32'd0};
        i_rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.func = FUNC_LOAD_VIEW;
        cmd_ch.element_index = '0;
        cmd_ch.element_value = '0;
        cmd_ch.min_x = '0;
        cmd_ch.min_y = '0;
        cmd_ch.min_z = '0;
        cmd_ch.max_x = '0;
        cmd_ch.max_y = '0;
        cmd_ch.max_z = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: all-zero planes, zero-normal derive, extremes, inverted box.
        send_box(32'h8000_0000, 32'h7FFF_FFFF);
        send_beat(FUNC_DERIVE, 4'd0, 32'd0, box);
        send_beat(FUNC_LOAD_VIEW, 4'd15, 32'h7FFF_FFFF, box);
        send_beat(FUNC_LOAD_VIEW, 4'd0, 32'h8000_0000, box);
        send_beat(FUNC_LOAD_PROJ, 4'd15, 32'h7FFF_FFFF, box);
        send_beat(FUNC_LOAD_PROJ, 4'd0, 32'h8000_0000, box);
        send_beat(FUNC_DERIVE, 4'd0, 32'd0, box);
        send_box(32'h7FFF_FFFF, 32'h8000_0000);
        send_box(32'h8000_0000, 32'h8000_0000);
        send_box(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_box(32'd0, 32'd0);

        // Random part: frames of loads and a derive, then many box tests with occasional stray loads.
        while (beats_sent < 1550) begin
            if (beats_sent > 1350) calm_phase = 1'b1;
            load_frame($urandom_range(0, 5) == 0);
            repeat ($urandom_range(20, 60)) begin
                if ($urandom_range(0, 30) == 0)
                    send_beat(t_func'($urandom_range(0, 1)), 4'($urandom()), pick_value(), box);
                else
                    send_random_box();
            end
        end
        cmd_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
